@@ src/mdef_pkg.sv @@
// Package for the dead-end fill maze solver: sizes, codes and the result record.
// No dependencies.
package mdef_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int MAX_ROWS    = 32;
    localparam int COL_W       = 5;
    localparam int ROW_W       = 5;
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DIM_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int STEPS_W     = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd5;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] DIR_LEFT   = 2'd0;
    localparam logic [1:0] DIR_RIGHT  = 2'd1;
    localparam logic [1:0] DIR_TOP    = 2'd2;
    localparam logic [1:0] DIR_BOTTOM = 2'd3;

    typedef struct packed {
        logic               solve_done;
        logic               solve_error;
        logic               on_path;
        logic               hint_valid;
        logic [COL_W-1:0]   hint_x;
        logic [ROW_W-1:0]   hint_y;
        logic [STEPS_W-1:0] steps_left;
    } t_result;

endpackage

@@ src/mdef_if.sv @@
// Stream and configuration channel interfaces for the maze solver.
// Depends on mdef_pkg.
interface mdef_in_if import mdef_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [COL_W-1:0] cell_x;
    logic [ROW_W-1:0] cell_y;
    logic             wall_left;
    logic             wall_right;
    logic             wall_top;
    logic             wall_bottom;
    logic             last_cell;
    modport source (output valid, kind, cell_x, cell_y, wall_left, wall_right,
                    wall_top, wall_bottom, last_cell, input ready);
    modport sink   (input valid, kind, cell_x, cell_y, wall_left, wall_right,
                    wall_top, wall_bottom, last_cell, output ready);
endinterface

interface mdef_out_if import mdef_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               solve_done;
    logic               solve_error;
    logic               on_path;
    logic               hint_valid;
    logic [COL_W-1:0]   hint_x;
    logic [ROW_W-1:0]   hint_y;
    logic [STEPS_W-1:0] steps_left;
    modport source (output valid, solve_done, solve_error, on_path, hint_valid,
                    hint_x, hint_y, steps_left, input ready);
    modport sink   (input valid, solve_done, solve_error, on_path, hint_valid,
                    hint_x, hint_y, steps_left, output ready);
endinterface

interface mdef_cfg_if import mdef_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [DIM_W-1:0]     wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ src/mdef_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mdef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/maze_dead_end_fill_solver_core.sv @@
// Top level of the dead-end fill maze solver: sequencer, four cell memories.
// Depends on mdef_pkg, mdef_if.sv and mdef_ram.
//
//  channel  | dir | contents
//  ---------+-----+--------------------------------------------------
//  i_in     | in  | kind, cell_x, cell_y, four wall bits, last_cell
//  o_out    | out | solve_done, solve_error, on_path, hint, steps_left
//  i_cfg    | in  | reg_index, wdata (always ready)
//
// A plain load only writes the wall memory; a query steps Q1, Q2, optionally Q3, then hands off.
// A solving load clears the fill and order memories, then scans each cell and probes
// its sides (one fill read per side), walks the open path from start to end, then
// writes each path cell's order. Reset loads config defaults and clears the path length.
// Input is not ready while any item is in work; a finished result waits in the
// output register and holds the sequencer only while that register is full.
module maze_dead_end_fill_solver_core
    import mdef_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mdef_in_if.sink   i_in,
    mdef_out_if.source o_out,
    mdef_cfg_if.sink  i_cfg
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_FSCAN = 4'd2;
    localparam logic [3:0] ST_PROBE = 4'd3;
    localparam logic [3:0] ST_FEVAL = 4'd4;
    localparam logic [3:0] ST_WINIT = 4'd5;
    localparam logic [3:0] ST_WEVAL = 4'd6;
    localparam logic [3:0] ST_WEND  = 4'd7;
    localparam logic [3:0] ST_OR1   = 4'd8;
    localparam logic [3:0] ST_OR2   = 4'd9;
    localparam logic [3:0] ST_Q1    = 4'd10;
    localparam logic [3:0] ST_Q2    = 4'd11;
    localparam logic [3:0] ST_Q3    = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    // config
    logic [DIM_W-1:0] r_cols, r_rows;
    logic [COL_W-1:0] r_sx, r_ex;
    logic [ROW_W-1:0] r_sy, r_ey;

    logic [3:0]       r_state;
    logic             r_walk;
    logic [2:0]       r_s;
    logic [3:0]       r_fb;
    logic [COL_W-1:0] r_x, r_c;
    logic [ROW_W-1:0] r_y, r_r;
    logic [CNT_W-1:0] r_guard, r_total, r_n, r_k, r_count, r_clr;
    logic             r_qin;
    t_result          r_res, r_out;
    logic             r_out_valid;

    logic [DIM_W-1:0]        cols_used, rows_used;
    logic [2*DIM_W-1:0]      prod;
    logic                    in_acc, in_inside;
    logic [ADDR_W-1:0]       cur_addr;
    logic [ADDR_W-1:0]       nbr_addr;
    logic [3:0]              edge_b, blk;
    logic [2:0]              blk_cnt;
    logic [1:0]              open_dir;
    logic                    has_open;
    logic [COL_W-1:0]        mv_x;
    logic [ROW_W-1:0]        mv_y;

    logic                    wall_we, fill_we, ord_we, list_we;
    logic [ADDR_W-1:0]       wall_wa, fill_wa, ord_wa, list_wa, fill_ra, list_ra;
    logic [3:0]              wall_wd, wall_rd;
    logic                    fill_wd, fill_rd;
    logic [CNT_W-1:0]        ord_wd, ord_rd;
    logic [ADDR_W-1:0]       list_wd, list_rd;

    assign cols_used = (r_cols == '0) ? DIM_W'(1) :
                       (r_cols > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS) : r_cols;
    assign rows_used = (r_rows == '0) ? DIM_W'(1) :
                       (r_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_rows;
    assign prod      = cols_used * rows_used;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign in_inside   = ({1'b0, i_in.cell_x} < cols_used) && ({1'b0, i_in.cell_y} < rows_used);

    assign cur_addr = {r_y, r_x};

    always_comb begin
        unique case (r_s[1:0])
            DIR_LEFT:   nbr_addr = {r_y, r_x - COL_W'(1)};
            DIR_RIGHT:  nbr_addr = {r_y, r_x + COL_W'(1)};
            DIR_TOP:    nbr_addr = {r_y - ROW_W'(1), r_x};
            DIR_BOTTOM: nbr_addr = {r_y + ROW_W'(1), r_x};
            default:    nbr_addr = cur_addr;
        endcase
    end

    // side blocked: wall, grid edge, or filled neighbor
    assign edge_b[0] = (r_x == '0);
    assign edge_b[1] = (({1'b0, r_x} + DIM_W'(1)) >= cols_used);
    assign edge_b[2] = (r_y == '0);
    assign edge_b[3] = (({1'b0, r_y} + DIM_W'(1)) >= rows_used);
    assign blk       = wall_rd | edge_b | r_fb;
    assign blk_cnt   = 3'(blk[0]) + 3'(blk[1]) + 3'(blk[2]) + 3'(blk[3]);
    assign has_open  = (blk != 4'hF);

    always_comb begin
        priority if (!blk[0]) open_dir = DIR_LEFT;
        else if (!blk[1])     open_dir = DIR_RIGHT;
        else if (!blk[2])     open_dir = DIR_TOP;
        else                  open_dir = DIR_BOTTOM;
    end

    always_comb begin
        mv_x = r_x;
        mv_y = r_y;
        unique case (open_dir)
            DIR_LEFT:   mv_x = r_x - COL_W'(1);
            DIR_RIGHT:  mv_x = r_x + COL_W'(1);
            DIR_TOP:    mv_y = r_y - ROW_W'(1);
            DIR_BOTTOM: mv_y = r_y + ROW_W'(1);
            default:    mv_x = r_x;
        endcase
    end

    logic fill_go;
    assign fill_go = (r_guard <= r_total) && (blk_cnt == 3'd3) &&
                     !(r_x == r_sx && r_y == r_sy) && !(r_x == r_ex && r_y == r_ey);

    // memory ports
    always_comb begin
        wall_we = in_acc && (i_in.kind == KIND_LOAD) && in_inside;
        wall_wa = {i_in.cell_y, i_in.cell_x};
        wall_wd = {i_in.wall_bottom, i_in.wall_top, i_in.wall_right, i_in.wall_left};

        fill_we = 1'b0;
        fill_wa = cur_addr;
        fill_wd = 1'b1;
        ord_we  = 1'b0;
        ord_wa  = list_rd;
        ord_wd  = r_k + CNT_W'(1);
        list_we = 1'b0;
        list_wa = r_n[ADDR_W-1:0];
        list_wd = cur_addr;
        list_ra = r_k[ADDR_W-1:0];
        fill_ra = nbr_addr;

        unique case (r_state)
            ST_CLR: begin
                fill_we = 1'b1;
                fill_wa = r_clr[ADDR_W-1:0];
                fill_wd = 1'b0;
                ord_we  = 1'b1;
                ord_wa  = r_clr[ADDR_W-1:0];
                ord_wd  = '0;
            end
            ST_FEVAL: fill_we = fill_go;
            ST_WEVAL: begin
                fill_we = ((r_n + CNT_W'(1)) < r_total);
                list_we = fill_we;
            end
            ST_WEND: begin
                list_we = 1'b1;
                list_wd = {r_ey, r_ex};
            end
            ST_OR2: ord_we = 1'b1;
            ST_Q2:  list_ra = ord_rd[ADDR_W-1:0];
            default: ;
        endcase
    end

    mdef_ram #(.WIDTH(4), .DEPTH(CELLS)) u_wall (
        .i_clk(i_clk), .i_we(wall_we), .i_waddr(wall_wa), .i_wdata(wall_wd),
        .i_raddr(cur_addr), .o_rdata(wall_rd)
    );
    mdef_ram #(.WIDTH(1), .DEPTH(CELLS)) u_fill (
        .i_clk(i_clk), .i_we(fill_we), .i_waddr(fill_wa), .i_wdata(fill_wd),
        .i_raddr(fill_ra), .o_rdata(fill_rd)
    );
    mdef_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_wa), .i_wdata(ord_wd),
        .i_raddr(cur_addr), .o_rdata(ord_rd)
    );
    mdef_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_list (
        .i_clk(i_clk), .i_we(list_we), .i_waddr(list_wa), .i_wdata(list_wd),
        .i_raddr(list_ra), .o_rdata(list_rd)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= DIM_W'(32);
            r_rows <= DIM_W'(32);
            r_sx   <= '0;
            r_sy   <= '0;
            r_ex   <= COL_W'(31);
            r_ey   <= ROW_W'(31);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                CFG_COLUMNS: r_cols <= i_cfg.wdata;
                CFG_ROWS:    r_rows <= i_cfg.wdata;
                CFG_START_X: r_sx   <= i_cfg.wdata[COL_W-1:0];
                CFG_START_Y: r_sy   <= i_cfg.wdata[ROW_W-1:0];
                CFG_END_X:   r_ex   <= i_cfg.wdata[COL_W-1:0];
                CFG_END_Y:   r_ey   <= i_cfg.wdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_s         <= '0;
            r_walk      <= 1'b0;
        end else begin
            // in ST_DONE the output register is reloaded instead
            if (o_out.valid && o_out.ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_x   <= i_in.cell_x;
                        r_y   <= i_in.cell_y;
                        r_qin <= in_inside;
                        if (i_in.kind == KIND_QUERY) begin
                            r_res   <= '0;
                            r_state <= ST_Q1;
                        end else if (i_in.last_cell) begin
                            r_res   <= '{solve_done: 1'b1, default: '0};
                            r_count <= '0;
                            r_clr   <= '0;
                            r_total <= prod[CNT_W-1:0];
                            r_state <= ST_CLR;
                        end
                    end
                end
                ST_CLR: begin
                    r_clr <= r_clr + CNT_W'(1);
                    if (r_clr == CNT_W'(CELLS - 1)) begin
                        if (({1'b0, r_sx} >= cols_used) || ({1'b0, r_ex} >= cols_used) ||
                            ({1'b0, r_sy} >= rows_used) || ({1'b0, r_ey} >= rows_used) ||
                            (r_sx == r_ex && r_sy == r_ey)) begin
                            r_res.solve_error <= 1'b1;
                            r_state <= ST_DONE;
                        end else begin
                            r_c     <= '0;
                            r_r     <= '0;
                            r_state <= ST_FSCAN;
                        end
                    end
                end
                ST_FSCAN: begin
                    r_x     <= r_c;
                    r_y     <= r_r;
                    r_guard <= '0;
                    r_walk  <= 1'b0;
                    r_s     <= '0;
                    r_state <= ST_PROBE;
                end
                ST_PROBE: begin
                    // fill bit of side s-1 arrives in the cycle after its read
                    if (r_s != 3'd0) begin
                        r_fb[2'(r_s - 3'd1)] <= fill_rd;
                    end
                    r_s <= r_s + 3'd1;
                    if (r_s == 3'd4) begin
                        r_state <= r_walk ? ST_WEVAL : ST_FEVAL;
                    end
                end
                ST_FEVAL: begin
                    if (fill_go) begin
                        r_x     <= mv_x;
                        r_y     <= mv_y;
                        r_guard <= r_guard + CNT_W'(1);
                        r_s     <= '0;
                        r_state <= ST_PROBE;
                    end else if (({1'b0, r_c} + DIM_W'(1)) == cols_used) begin
                        r_c <= '0;
                        if (({1'b0, r_r} + DIM_W'(1)) == rows_used) begin
                            r_state <= ST_WINIT;
                        end else begin
                            r_r     <= r_r + ROW_W'(1);
                            r_state <= ST_FSCAN;
                        end
                    end else begin
                        r_c     <= r_c + COL_W'(1);
                        r_state <= ST_FSCAN;
                    end
                end
                ST_WINIT: begin
                    r_x     <= r_sx;
                    r_y     <= r_sy;
                    r_n     <= '0;
                    r_walk  <= 1'b1;
                    r_s     <= '0;
                    r_state <= ST_PROBE;
                end
                ST_WEVAL: begin
                    if ((r_n + CNT_W'(1)) >= r_total || !has_open) begin
                        r_res.solve_error <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_n <= r_n + CNT_W'(1);
                        r_x <= mv_x;
                        r_y <= mv_y;
                        r_s <= '0;
                        r_state <= (mv_x == r_ex && mv_y == r_ey) ? ST_WEND : ST_PROBE;
                    end
                end
                ST_WEND: begin
                    r_n     <= r_n + CNT_W'(1);
                    r_k     <= '0;
                    r_state <= ST_OR1;
                end
                ST_OR1: r_state <= ST_OR2;
                ST_OR2: begin
                    r_k <= r_k + CNT_W'(1);
                    if ((r_k + CNT_W'(1)) == r_n) begin
                        r_count <= r_n;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_OR1;
                    end
                end
                ST_Q1: r_state <= ST_Q2;
                ST_Q2: begin
                    // an empty path means every order entry reads as off path
                    if (r_qin && r_count != '0 && ord_rd != '0 && ord_rd <= r_count) begin
                        r_res.on_path    <= 1'b1;
                        r_res.steps_left <= STEPS_W'(r_count - ord_rd);
                        r_state <= (ord_rd < r_count) ? ST_Q3 : ST_DONE;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_Q3: begin
                    r_res.hint_valid <= 1'b1;
                    r_res.hint_x     <= list_rd[COL_W-1:0];
                    r_res.hint_y     <= list_rd[ADDR_W-1:COL_W];
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.solve_done  = r_out.solve_done;
    assign o_out.solve_error = r_out.solve_error;
    assign o_out.on_path     = r_out.on_path;
    assign o_out.hint_valid  = r_out.hint_valid;
    assign o_out.hint_x      = r_out.hint_x;
    assign o_out.hint_y      = r_out.hint_y;
    assign o_out.steps_left  = r_out.steps_left;

    a_solve_no_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.solve_done |-> !o_out.on_path && !o_out.hint_valid)
        else $error("solve result carries path fields");
    a_hint_on_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.hint_valid |-> o_out.on_path)
        else $error("hint off path");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.kind == KIND_QUERY |=> !i_in.ready)
        else $error("ready during query");
    a_err_only_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.solve_error |-> o_out.solve_done)
        else $error("error flag on query result");
endmodule
